// ===== hdl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int unsigned LEN_W = 24;
    localparam logic [LEN_W-1:0] MAX_FRAME_LEN_RESET = 24'd10485760;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_ZERO  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       frame_last;
    } result_t;

endpackage

// ===== hdl/lpd_parser.sv =====
// ----------------------------------------------------------------------------
// lpd_parser
// Header collection, length check and payload counting; one byte per transfer.
// ----------------------------------------------------------------------------
module lpd_parser
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [lpd_pkg::LEN_W-1:0]    cfg_write_data,
    input  logic                         accept,
    input  logic                         func,
    input  logic [7:0]                   data_byte,
    output logic                         res_valid,
    output lpd_pkg::result_t             res
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CLOSED  = 2'd2
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [1:0]                  hcount_reg, hcount_next;
    logic [lpd_pkg::LEN_W-1:0]   accum_reg, accum_next;
    logic [lpd_pkg::LEN_W-1:0]   remain_reg, remain_next;
    logic [lpd_pkg::LEN_W-1:0]   max_len_reg;
    logic [31:0]                 full_len;
    logic [lpd_pkg::LEN_W-1:0]   remain_dec;

    assign full_len   = {accum_reg, data_byte};
    assign remain_dec = remain_reg - lpd_pkg::LEN_W'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        hcount_next      = hcount_reg;
        accum_next       = accum_reg;
        remain_next      = remain_reg;
        res_valid        = 1'b0;
        res.kind         = lpd_pkg::KIND_BYTE;
        res.payload_byte = 8'd0;
        res.frame_last   = 1'b0;
        if (func)
        begin
            phase_next  = PH_HEADER;
            hcount_next = 2'd0;
            accum_next  = '0;
            remain_next = '0;
        end
        else
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    hcount_next = hcount_reg + 2'd1;
                    if (hcount_reg != 2'd3)
                    begin
                        accum_next = full_len[lpd_pkg::LEN_W-1:0];
                    end
                    else
                    begin
                        accum_next = '0;
                        res_valid  = 1'b1;
                        if (full_len == 32'd0)
                        begin
                            res.kind = lpd_pkg::KIND_ZERO;
                        end
                        else if (full_len > {8'd0, max_len_reg})
                        begin
                            res.kind   = lpd_pkg::KIND_ERROR;
                            phase_next = PH_CLOSED;
                        end
                        else
                        begin
                            res_valid   = 1'b0;
                            remain_next = full_len[lpd_pkg::LEN_W-1:0];
                            phase_next  = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    remain_next      = remain_dec;
                    res_valid        = 1'b1;
                    res.payload_byte = data_byte;
                    res.frame_last   = (remain_dec == '0);
                    if (remain_dec == '0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hcount_reg  <= 2'd0;
            accum_reg   <= '0;
            remain_reg  <= '0;
            max_len_reg <= lpd_pkg::MAX_FRAME_LEN_RESET;
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_len_reg <= cfg_write_data;
            end
            if (accept)
            begin
                phase_reg  <= phase_next;
                hcount_reg <= hcount_next;
                accum_reg  <= accum_next;
                remain_reg <= remain_next;
            end
        end
    end

endmodule

// ===== hdl/lpd_out_buf.sv =====
// ----------------------------------------------------------------------------
// lpd_out_buf
// Result register with a skid stage; full when the skid entry is occupied.
// ----------------------------------------------------------------------------
module lpd_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lpd_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output lpd_pkg::result_t out_data
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    lpd_pkg::result_t main_reg;
    lpd_pkg::result_t skid_reg;
    logic             pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    main_valid_reg <= push;
                end
            end
            else if (!main_valid_reg)
            begin
                main_valid_reg <= push;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        else if (push && (pop || !main_valid_reg))
        begin
            main_reg <= push_data;
        end
        if (push && !pop && main_valid_reg)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

// ===== hdl/length_prefix_deframer_core.sv =====
// ----------------------------------------------------------------------------
// length_prefix_deframer_core
// Splits a byte stream into frames with a 4-byte big-endian length prefix.
//
// Input channel (in_valid/in_stall): one transfer per byte; func high marks a
// connection start, which clears the parse state. Output channel
// (out_valid/out_stall): kind, payload_byte and frame_last per result.
// Header bytes produce no result; the fourth one produces a zero-length or
// oversize result when one applies. After an oversize length the stream is
// closed and data bytes are dropped until the next connection start.
// cfg_write_en/cfg_write_data load max_frame_len; write it only while the
// block is idle.
// Throughput: one input transfer per cycle while in_stall is low. Results
// are presented from the result register.
// When the receiver stalls, results collect in the result register and one
// skid entry; in_stall rises once the skid entry is full.
// Reset clears the parse state and output queue and loads max_frame_len with
// 10485760.
// ----------------------------------------------------------------------------
module length_prefix_deframer_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [23:0]               cfg_write_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic [7:0]                data_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                kind,
    output logic [7:0]                payload_byte,
    output logic                      frame_last
);

    logic             accept;
    logic             res_valid;
    lpd_pkg::result_t res;
    lpd_pkg::result_t out_data;
    logic             buf_full;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    lpd_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .accept         (accept),
        .func           (func),
        .data_byte      (data_byte),
        .res_valid      (res_valid),
        .res            (res)
    );

    lpd_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind         = out_data.kind;
    assign payload_byte = out_data.payload_byte;
    assign frame_last   = out_data.frame_last;

endmodule

// ===== test/tb_length_prefix_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefix_deframer_core
// Self-checking bench for the length-prefix deframer. A queue of byte
// transfers (framed traffic with random content, zero-length and oversize
// headers, aborted frames and stray bytes) feeds a bursty driver. The receiver
// stalls on its own pattern. A behavioral deframer predicts every result and
// the monitor compares each output transfer against it, over several
// max_frame_len settings written while the block is idle.
// ----------------------------------------------------------------------------
module tb_length_prefix_deframer_core;

    localparam logic FUNC_DATA    = 1'b0;
    localparam logic FUNC_CONNECT = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        ST_HEADER  = 2'd0,
        ST_PAYLOAD = 2'd1,
        ST_CLOSED  = 2'd2
    } parse_state_t;

    typedef struct packed {
        logic       func;
        logic [7:0] data;
    } stream_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [23:0] cfg_write_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        func = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        frame_last;

    length_prefix_deframer_core u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .frame_last     (frame_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // behavioral deframer state
    parse_state_t parse_state = ST_HEADER;
    logic [1:0]   hdr_count = '0;
    logic [31:0]  len_accum = '0;
    logic [23:0]  bytes_left = '0;
    logic [23:0]  max_len = lpd_pkg::MAX_FRAME_LEN_RESET;

    stream_item_t       byte_queue[$];
    lpd_pkg::result_t   pending_results[$];
    int unsigned        mismatch_count = 0;

    task automatic queue_result(input lpd_pkg::kind_t k, input logic [7:0] b,
                                input logic last);
        lpd_pkg::result_t r;
        r.kind = k;
        r.payload_byte = b;
        r.frame_last = last;
        pending_results.push_back(r);
    endtask

    task automatic advance_deframer(input stream_item_t it);
        if (it.func == FUNC_CONNECT)
        begin
            parse_state = ST_HEADER;
            hdr_count = '0;
            len_accum = '0;
            bytes_left = '0;
        end
        else
        begin
            case (parse_state)
                ST_HEADER:
                begin
                    len_accum = {len_accum[23:0], it.data};
                    hdr_count = hdr_count + 2'd1;
                    if (hdr_count == 2'd0)
                    begin
                        if (len_accum == 32'd0)
                            queue_result(lpd_pkg::KIND_ZERO, 8'd0, 1'b0);
                        else if (len_accum > {8'd0, max_len})
                        begin
                            parse_state = ST_CLOSED;
                            queue_result(lpd_pkg::KIND_ERROR, 8'd0, 1'b0);
                        end
                        else
                        begin
                            bytes_left = len_accum[23:0];
                            parse_state = ST_PAYLOAD;
                        end
                        len_accum = '0;
                    end
                end
                ST_PAYLOAD:
                begin
                    bytes_left = bytes_left - 24'd1;
                    if (bytes_left == 24'd0)
                        parse_state = ST_HEADER;
                    queue_result(lpd_pkg::KIND_BYTE, it.data, bytes_left == 24'd0);
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // driver: bursts of transfers with gaps between them
    stream_item_t cur_item = '0;
    int unsigned  burst_left = 1;
    int unsigned  gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                advance_deframer(cur_item);
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (byte_queue.size() != 0)
                begin
                    cur_item = byte_queue.pop_front();
                    func <= cur_item.func;
                    data_byte <= cur_item.data;
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(64, 200);
                        gap_left = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(1, 8);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    int unsigned stall_mode = 0;
    int unsigned stall_span = 0;
    int unsigned stall_tick = 0;

    task automatic note_mismatch(input string what, input lpd_pkg::result_t want,
                                 input lpd_pkg::result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: exp kind=%0d byte=%02h last=%0d, got kind=%0d byte=%02h last=%0d",
                     what, want.kind, want.payload_byte, want.frame_last,
                     got.kind, got.payload_byte, got.frame_last);
    endtask

    always @(posedge clk)
    begin
        lpd_pkg::result_t want;
        lpd_pkg::result_t got;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.kind = lpd_pkg::kind_t'(kind);
                got.payload_byte = payload_byte;
                got.frame_last = frame_last;
                if (pending_results.size() == 0)
                    note_mismatch("unexpected transfer", '0, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind || payload_byte !== want.payload_byte ||
                        frame_last !== want.frame_last)
                        note_mismatch("result mismatch", want, got);
                end
            end
            stall_tick++;
            if (stall_span == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_span = $urandom_range(16, 200);
            end
            else
                stall_span--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ((stall_tick % 7) < 3);
            endcase
        end
    end

    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_item(input logic f, input logic [7:0] d);
        stream_item_t it;
        it.func = f;
        it.data = d;
        byte_queue.push_back(it);
    endtask

    task automatic push_header(input logic [31:0] len);
        push_item(FUNC_DATA, len[31:24]);
        push_item(FUNC_DATA, len[23:16]);
        push_item(FUNC_DATA, len[15:8]);
        push_item(FUNC_DATA, len[7:0]);
    endtask

    function automatic logic [31:0] pick_len(input logic [23:0] lim);
        int unsigned r;
        int unsigned hi;
        logic [31:0] len;
        r = $urandom_range(0, 99);
        if (r < 6)
            len = 32'd0;
        else if (r < 14)
        begin
            if ($urandom_range(0, 1) == 0)
                len = {8'd0, lim} + 32'd1;
            else
            begin
                len = $urandom;
                if (len <= {8'd0, lim})
                    len = {8'd0, lim} + 32'd1 + ($urandom & 32'h00FF_0000);
            end
        end
        else if (r < 20 && lim != 0 && lim <= 48)
            len = {8'd0, lim};
        else
        begin
            hi = (lim == 0 || lim > 32) ? 32 : lim;
            len = $urandom_range(1, hi);
        end
        return len;
    endfunction

    task automatic queue_traffic(input int unsigned target, input logic [23:0] lim);
        int unsigned made;
        int unsigned r;
        int unsigned k;
        logic [31:0] len;
        made = 0;
        push_item(FUNC_CONNECT, $urandom_range(0, 255));
        while (made < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                push_item(FUNC_CONNECT, $urandom_range(0, 255));
                made++;
            end
            else if (r < 10)
            begin
                k = $urandom_range(1, 3);
                repeat (k) push_item(FUNC_DATA, $urandom_range(0, 255));
                push_item(FUNC_CONNECT, $urandom_range(0, 255));
                made += k + 1;
            end
            else
            begin
                len = pick_len(lim);
                push_header(len);
                made += 4;
                if (len > {8'd0, lim})
                begin
                    repeat ($urandom_range(0, 3)) push_item(FUNC_DATA, $urandom_range(0, 255));
                    push_item(FUNC_CONNECT, $urandom_range(0, 255));
                    made++;
                end
                else if (len != 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        k = $urandom_range(0, len - 1);
                        repeat (k) push_item(FUNC_DATA, $urandom_range(0, 255));
                        push_item(FUNC_CONNECT, $urandom_range(0, 255));
                        made += k + 1;
                    end
                    else
                    begin
                        repeat (len) push_item(FUNC_DATA, $urandom_range(0, 255));
                        made += len;
                    end
                end
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_queue.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_max_len(input logic [23:0] v);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        max_len = v;
        @(negedge clk);
    endtask

    initial
    begin
        logic [23:0] mid_len;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed traffic at the reset maximum
        push_item(FUNC_CONNECT, 8'hFF);
        push_header(32'd0);
        push_header(32'd2);
        push_item(FUNC_DATA, 8'hFF);
        push_item(FUNC_DATA, 8'h00);
        push_header(32'd3);
        push_item(FUNC_DATA, 8'h5A);
        push_item(FUNC_CONNECT, 8'h00);
        push_header(32'hFFFF_FFFF);
        push_item(FUNC_DATA, 8'h7E);
        push_item(FUNC_CONNECT, 8'hA5);
        push_header({8'd0, lpd_pkg::MAX_FRAME_LEN_RESET} + 32'd1);
        wait_idle();

        write_max_len(24'd1);
        queue_traffic(200, 24'd1);
        wait_idle();

        write_max_len(24'hFF_FFFF);
        push_item(FUNC_CONNECT, 8'h00);
        push_header(32'h00FF_FFFF);
        push_item(FUNC_DATA, 8'h01);
        push_item(FUNC_DATA, 8'hFE);
        push_item(FUNC_DATA, 8'h80);
        push_item(FUNC_CONNECT, 8'h00);
        push_header(32'h0100_0000);
        queue_traffic(250, 24'hFF_FFFF);
        wait_idle();

        write_max_len(24'd0);
        queue_traffic(120, 24'd0);
        wait_idle();

        mid_len = $urandom_range(2, 48);
        write_max_len(mid_len);
        queue_traffic(250, mid_len);
        wait_idle();

        write_max_len(lpd_pkg::MAX_FRAME_LEN_RESET);
        queue_traffic(280, lpd_pkg::MAX_FRAME_LEN_RESET);
        wait_idle();

        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
